// ----- rtl/atf_pkg.sv -----
// Shared types, constants and the arctangent table for the tilt angle filter.
`timescale 1ns / 1ps

package atf_pkg;

    localparam int DATA_W      = 16;   // axis sample and result field width
    localparam int ITER_W      = 5;    // iteration index, covers the 24-entry table
    localparam int ATAN_LEN    = 24;
    localparam int ATAN_W      = 23;   // unsigned width of one table entry
    localparam int DP_W        = 27;   // CORDIC x/y datapath, signed
    localparam int ANG_ACC_W   = 25;   // CORDIC angle accumulator, degrees Q16, signed
    localparam int PRESCALE    = 8;
    localparam int MUL_B_W     = 16;
    localparam int MUL_P_W     = DP_W + MUL_B_W + 1;
    localparam int COEF_W      = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_ANGLE_FRAC_BITS   = 8;
    localparam int DEF_CORDIC_ITERATIONS = 16;

    localparam logic [MUL_B_W-1:0] INV_GAIN = 16'd39797;  // 1/K, Q16
    localparam logic [COEF_W-1:0]  FB_RESET = 15'd31130;
    localparam logic [COEF_W-1:0]  FF_RESET = 15'd819;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEEDBACK    = 2'd0,
        REG_FEEDFORWARD = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS1,
        S_GAIN,
        S_LOAD2,
        S_PASS2,
        S_ROUND,
        S_FB,
        S_FF0,
        S_FF1,
        S_SUM,
        S_DONE
    } atf_state_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [ITER_W-1:0] iter;
    } cordic_ctrl_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [ITER_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/atf_in_if.sv -----
// Sample channel: three signed axis readings with valid/ready.
`timescale 1ns / 1ps

interface atf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

// ----- rtl/atf_out_if.sv -----
// Result channel: filtered and raw tilt angle with valid/ready.
`timescale 1ns / 1ps

interface atf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] filtered_angle;
    logic signed [15:0] raw_angle;

    modport source (output valid, output filtered_angle, output raw_angle, input ready);
    modport sink   (input valid, input filtered_angle, input raw_angle, output ready);
endinterface

// ----- rtl/atf_cfg_if.sv -----
// Configuration write channel: register index and data with valid/ready.
`timescale 1ns / 1ps

interface atf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/atf_cordic.sv -----
// Shared CORDIC vectoring unit: one shift-add iteration per step.
`timescale 1ns / 1ps

module atf_cordic
    import atf_pkg::*;
(
    input  logic                        clk,
    input  cordic_ctrl_t                ctrl,
    input  logic signed [DP_W-1:0]      x_init,
    input  logic signed [DP_W-1:0]      y_init,
    output logic signed [DP_W-1:0]      x,
    output logic signed [ANG_ACC_W-1:0] ang
);

    logic signed [DP_W-1:0]      x_reg, x_next;
    logic signed [DP_W-1:0]      y_reg, y_next;
    logic signed [ANG_ACC_W-1:0] ang_reg, ang_next;
    logic signed [DP_W-1:0]      dx, dy;
    logic signed [ANG_ACC_W-1:0] da;

    always_comb
    begin
        dx       = y_reg >>> ctrl.iter;
        dy       = x_reg >>> ctrl.iter;
        da       = signed'({{(ANG_ACC_W-ATAN_W){1'b0}}, atan_deg(ctrl.iter)});
        x_next   = x_reg;
        y_next   = y_reg;
        ang_next = ang_reg;
        if (ctrl.load)
        begin
            x_next   = x_init;
            y_next   = y_init;
            ang_next = '0;
        end
        else if (ctrl.step)
        begin
            // zero residual rotates as nonnegative
            if (!y_reg[DP_W-1])
            begin
                x_next   = x_reg + dx;
                y_next   = y_reg - dy;
                ang_next = ang_reg + da;
            end
            else
            begin
                x_next   = x_reg - dx;
                y_next   = y_reg + dy;
                ang_next = ang_reg - da;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign x   = x_reg;
    assign ang = ang_reg;

endmodule

// ----- rtl/atf_mul.sv -----
// Shared registered multiplier: signed datapath value times unsigned factor.
`timescale 1ns / 1ps

module atf_mul
    import atf_pkg::*;
(
    input  logic                      clk,
    input  logic signed [DP_W-1:0]    a,
    input  logic [MUL_B_W-1:0]        b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg, p_next;

    assign p_next = a * signed'({1'b0, b});

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- rtl/accel_tilt_angle_filter.sv -----
// Top level: tilt angle from one accelerometer sample, then first-order low-pass.
`timescale 1ns / 1ps

// Accepts one three-axis sample on "sample" and returns one item on "result":
// the raw tilt angle atan(y / sqrt(x^2 + z^2)) and its low-pass filtered value,
// both in 1/2^ANGLE_FRAC_BITS degree units and limited to +-90 degrees. One
// CORDIC shift-add unit runs twice per sample: first on (|x|, |z|) to form the
// root magnitude, which the shared multiplier scales by the inverse CORDIC gain,
// then on (root, y) to accumulate the angle from the arctangent table. The same
// multiplier then forms the three filter products (Q0.15 coefficients) one per
// cycle. Each pass runs min(CORDIC_ITERATIONS, 24) iterations of the CORDIC
// unit, one per cycle. A sample with x and z both zero skips both passes.
// Input ready is high only while the sequencer is idle; a finished item waits
// in the result register while the next sample is already taken, and the
// sequencer holds at its last step until that register is free.
// Coefficient writes (index 0 feedback, index 1 feedforward, low 15 bits kept,
// other indexes ignored) are always accepted and must be issued while idle.

module accel_tilt_angle_filter
    import atf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS   = DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
)
(
    input  logic      clk,
    input  logic      rst_n,
    atf_in_if.sink    sample,
    atf_out_if.source result,
    atf_cfg_if.sink   cfg
);

    // angle word holds +-(90 << frac) plus sign
    localparam int ANG_W      = ANGLE_FRAC_BITS + 8;
    localparam int ACC_W      = ANG_W + 2;              // sum of three products
    localparam int FRAC_SHIFT = 16 - ANGLE_FRAC_BITS;   // Q16 degrees down to output
    localparam int ITER_N     = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
    localparam int ANGLE_LIM  = 90 << ANGLE_FRAC_BITS;

    localparam logic signed [ANG_ACC_W-1:0] LIM_ACC   = ANG_ACC_W'(ANGLE_LIM);
    localparam logic signed [ANG_W-1:0]     LIM_ANG   = ANG_W'(ANGLE_LIM);
    localparam logic signed [ACC_W-1:0]     LIM_SUM   = ACC_W'(ANGLE_LIM);
    localparam logic signed [ANG_ACC_W-1:0] ANG_HALF  = ANG_ACC_W'(1 << (FRAC_SHIFT - 1));
    localparam logic [ITER_W-1:0]           ITER_LAST = ITER_W'(ITER_N - 1);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    atf_state_t state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;
    logic [COEF_W-1:0] fb_reg, fb_next;
    logic [COEF_W-1:0] ff_reg, ff_next;
    logic signed [ANG_W-1:0] prev_filt_reg, prev_filt_next;
    logic signed [ANG_W-1:0] prev_raw_reg, prev_raw_next;

    // payload, no reset
    logic signed [DATA_W-1:0] ay_reg, ay_next;
    logic signed [ANG_W-1:0]  raw_reg, raw_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // ---------------------------------------------------------------
    // Shared units
    // ---------------------------------------------------------------
    cordic_ctrl_t                cctl;
    logic signed [DP_W-1:0]      c_x_init, c_y_init, c_x;
    logic signed [ANG_ACC_W-1:0] c_ang;
    logic signed [DP_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;

    atf_cordic u_cordic (
        .clk    (clk),
        .ctrl   (cctl),
        .x_init (c_x_init),
        .y_init (c_y_init),
        .x      (c_x),
        .ang    (c_ang)
    );

    atf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic                       in_acc;
    logic                       xz_zero;
    logic signed [DP_W-1:0]     ax_ext, az_ext, ay_ext;
    logic signed [DP_W-1:0]     root;
    logic signed [ACC_W-1:0]    prod_rnd;
    logic signed [ANG_ACC_W-1:0] ang_rnd;
    logic signed [ANG_W-1:0]    raw_clamped;
    logic signed [ANG_W-1:0]    filt_clamped;
    logic signed [ANG_W-1:0]    raw_special;
    logic                       out_free;

    assign sample.ready = (state_reg == S_IDLE);
    assign in_acc       = sample.valid && sample.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;

    assign xz_zero = (sample.accel_x == '0) && (sample.accel_z == '0);
    assign ax_ext  = DP_W'(sample.accel_x);
    assign az_ext  = DP_W'(sample.accel_z);
    assign ay_ext  = DP_W'(ay_reg);

    // round half up, negative filter products included
    assign root     = DP_W'((mul_p + MUL_P_W'(32768)) >>> 16);
    assign prod_rnd = ACC_W'((mul_p + MUL_P_W'(16384)) >>> 15);
    assign ang_rnd  = (c_ang + ANG_HALF) >>> FRAC_SHIFT;

    always_comb
    begin
        if (ang_rnd > LIM_ACC)
            raw_clamped = LIM_ANG;
        else if (ang_rnd < -LIM_ACC)
            raw_clamped = -LIM_ANG;
        else
            raw_clamped = ANG_W'(ang_rnd);

        if (acc_reg > LIM_SUM)
            filt_clamped = LIM_ANG;
        else if (acc_reg < -LIM_SUM)
            filt_clamped = -LIM_ANG;
        else
            filt_clamped = ANG_W'(acc_reg);

        // straight up or down when there is no horizontal component
        if (sample.accel_y > 0)
            raw_special = LIM_ANG;
        else if (sample.accel_y < 0)
            raw_special = -LIM_ANG;
        else
            raw_special = '0;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        prev_filt_next = prev_filt_reg;
        prev_raw_next  = prev_raw_reg;
        ay_next        = ay_reg;
        raw_next       = raw_reg;
        acc_next       = acc_reg;
        cctl           = '0;
        cctl.iter      = iter_reg;
        c_x_init       = root;
        c_y_init       = ay_ext <<< PRESCALE;
        mul_a          = c_x;
        mul_b          = INV_GAIN;

        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                c_x_init = (ax_ext[DP_W-1] ? -ax_ext : ax_ext) <<< PRESCALE;
                c_y_init = (az_ext[DP_W-1] ? -az_ext : az_ext) <<< PRESCALE;
                if (in_acc)
                begin
                    ay_next   = sample.accel_y;
                    iter_next = '0;
                    if (xz_zero)
                    begin
                        raw_next   = raw_special;
                        state_next = S_FB;
                    end
                    else
                    begin
                        cctl.load  = 1'b1;
                        state_next = S_PASS1;
                    end
                end
            end

            S_PASS1:
            begin
                cctl.step = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                    state_next = S_GAIN;
            end

            S_GAIN:
            begin
                mul_a      = c_x;
                mul_b      = INV_GAIN;
                state_next = S_LOAD2;
            end

            S_LOAD2:
            begin
                cctl.load  = 1'b1;
                iter_next  = '0;
                state_next = S_PASS2;
            end

            S_PASS2:
            begin
                cctl.step = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                    state_next = S_ROUND;
            end

            S_ROUND:
            begin
                raw_next   = raw_clamped;
                state_next = S_FB;
            end

            S_FB:
            begin
                mul_a      = DP_W'(prev_filt_reg);
                mul_b      = MUL_B_W'(fb_reg);
                state_next = S_FF0;
            end

            S_FF0:
            begin
                mul_a      = DP_W'(raw_reg);
                mul_b      = MUL_B_W'(ff_reg);
                acc_next   = prod_rnd;
                state_next = S_FF1;
            end

            S_FF1:
            begin
                mul_a      = DP_W'(prev_raw_reg);
                mul_b      = MUL_B_W'(ff_reg);
                acc_next   = acc_reg + prod_rnd;
                state_next = S_SUM;
            end

            S_SUM:
            begin
                acc_next   = acc_reg + prod_rnd;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // filter history doubles as the result register
                if (out_free)
                begin
                    prev_filt_next = filt_clamped;
                    prev_raw_next  = raw_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // coefficient writes
    always_comb
    begin
        fb_next = fb_reg;
        ff_next = ff_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_FEEDBACK:    fb_next = cfg.data[COEF_W-1:0];
                REG_FEEDFORWARD: ff_next = cfg.data[COEF_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            fb_reg        <= FB_RESET;
            ff_reg        <= FF_RESET;
            prev_filt_reg <= '0;
            prev_raw_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            fb_reg        <= fb_next;
            ff_reg        <= ff_next;
            prev_filt_reg <= prev_filt_next;
            prev_raw_reg  <= prev_raw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ay_reg  <= ay_next;
        raw_reg <= raw_next;
        acc_reg <= acc_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.filtered_angle = DATA_W'(prev_filt_reg);
    assign result.raw_angle      = DATA_W'(prev_raw_reg);

`ifndef NO_ASSERTIONS
    a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !cctl.step)
        else $error("CORDIC stepping while idle");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_PASS1 || state_reg == S_FB))
        else $error("sample accepted but sequencer did not start");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(prev_filt_reg) && $stable(prev_raw_reg))
        else $error("pending result overwritten");

    a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (prev_filt_reg <= LIM_ANG && prev_filt_reg >= -LIM_ANG
                           && prev_raw_reg <= LIM_ANG && prev_raw_reg >= -LIM_ANG))
        else $error("angle outside +-90 degrees");
`endif

endmodule
